/* src/loop_branch_predictor_table_macros.svh */
// ----------------------------------------------------------------------------
// Loop branch predictor table assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LOOP_BRANCH_PREDICTOR_TABLE_MACROS_SVH
`define LOOP_BRANCH_PREDICTOR_TABLE_MACROS_SVH

// Same-cycle implication.
`define LBPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LBPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lbpt_pkg.sv */
// ----------------------------------------------------------------------------
// Loop branch predictor table package
// Widths, operation and status codes, and lookup flags shared by the block.
// ----------------------------------------------------------------------------
package lbpt_pkg;

  localparam int unsigned LBPT_TABLE_ENTRIES = 32;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned COUNT_W = 16;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    OP_PREDICT = 2'd0,
    OP_TRIP    = 2'd1,
    OP_INSERT  = 2'd2,
    OP_SQUASH  = 2'd3
  } lbpt_op_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_TRIP_MISS   = 2'd1,
    ST_INSERT_FULL = 2'd2
  } lbpt_status_e;

  typedef struct packed {
    logic hit;
    logic free_found;
  } lbpt_lookup_t;

endpackage

/* src/lbpt_if.sv */
// ----------------------------------------------------------------------------
// Loop branch predictor table channels
// Valid/ready interfaces for the request, response and configuration channels.
// ----------------------------------------------------------------------------
interface lbpt_req_if;
  import lbpt_pkg::*;

  logic     valid;
  logic     ready;
  lbpt_op_e opcode;
  addr_t    branch_addr;
  addr_t    target_addr;
  addr_t    exit_target;
  count_t   iteration_limit;

  modport source (
    output valid, opcode, branch_addr, target_addr, exit_target, iteration_limit,
    input  ready
  );
  modport sink (
    input  valid, opcode, branch_addr, target_addr, exit_target, iteration_limit,
    output ready
  );
endinterface

interface lbpt_rsp_if;
  import lbpt_pkg::*;

  logic         valid;
  logic         ready;
  logic         hit;
  logic         prediction_valid;
  addr_t        predicted_target;
  lbpt_status_e status;

  modport source (
    output valid, hit, prediction_valid, predicted_target, status,
    input  ready
  );
  modport sink (
    input  valid, hit, prediction_valid, predicted_target, status,
    output ready
  );
endinterface

interface lbpt_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

/* src/lbpt_lookup.sv */
// ----------------------------------------------------------------------------
// Loop branch predictor table lookup
// Parallel tag compare with lowest-match and lowest-free priority encoders.
// ----------------------------------------------------------------------------
module lbpt_lookup #(
  parameter int unsigned Entries = lbpt_pkg::LBPT_TABLE_ENTRIES,
  localparam int unsigned IdxW = $clog2(Entries)
) (
  input  lbpt_pkg::addr_t        key_i,
  input  logic [Entries-1:0]     slot_used_i,
  input  lbpt_pkg::addr_t        entry_branch_i [Entries],
  output lbpt_pkg::lbpt_lookup_t lookup_o,
  output logic [IdxW-1:0]        hit_idx_o,
  output logic [IdxW-1:0]        free_idx_o
);
  import lbpt_pkg::*;

  logic [Entries-1:0] match;

  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      match[i] = slot_used_i[i] && (entry_branch_i[i] == key_i);
    end
  end

  always_comb begin
    hit_idx_o  = '0;
    free_idx_o = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx_o = IdxW'(i);
      end
      if (!slot_used_i[i]) begin
        free_idx_o = IdxW'(i);
      end
    end
    lookup_o.hit        = |match;
    lookup_o.free_found = ~&slot_used_i;
  end

endmodule

/* src/loop_branch_predictor_table.sv */
// A request is captured in the request register, then moved to the response register when
// that is empty or being taken; a response held by rsp_o.ready low stalls both stages.
// Throughput: one request per cycle unless the response stalls; the table is read and updated
// in the single stage between the two registers, so back-to-back items see it.
// Reset: all slots empty, new_entry_valid set to 1, both stages empty; ready right away.
// ----------------------------------------------------------------------------
// Loop branch predictor table
// Fully associative table of loop entries with predict, trip update, insert
// and squash operations, one per request.
// ----------------------------------------------------------------------------
`include "loop_branch_predictor_table_macros.svh"

module loop_branch_predictor_table #(
  parameter int unsigned TABLE_ENTRIES = lbpt_pkg::LBPT_TABLE_ENTRIES
) (
  input logic         clk_i,
  input logic         rst_ni,
  lbpt_cfg_if.sink    cfg_i,
  lbpt_req_if.sink    req_i,
  lbpt_rsp_if.source  rsp_o
);
  import lbpt_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);

  logic cfg_new_valid_q;

  logic     s1_valid_q;
  lbpt_op_e s1_op_q;
  addr_t    s1_key_q;
  addr_t    s1_tgt_q;
  addr_t    s1_ext_q;
  count_t   s1_lim_q;

  logic [TABLE_ENTRIES-1:0] slot_used_q;
  addr_t                    entry_branch_q      [TABLE_ENTRIES];
  addr_t                    entry_loop_target_q [TABLE_ENTRIES];
  addr_t                    entry_exit_target_q [TABLE_ENTRIES];
  count_t                   entry_trip_count_q  [TABLE_ENTRIES];
  count_t                   entry_limit_q       [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] entry_valid_q;

  lbpt_lookup_t    lkp;
  logic [IdxW-1:0] hit_idx;
  logic [IdxW-1:0] free_idx;

  addr_t  sel_loop;
  addr_t  sel_exit;
  count_t sel_cnt;
  count_t sel_lim;
  logic   sel_valid;
  logic   at_limit;
  logic   advance;
  logic   req_xfer;
  logic   do_alloc;

  logic         res_pv;
  addr_t        res_pt;
  lbpt_status_e res_st;

  logic         rsp_valid_q;
  logic         rsp_hit_q;
  logic         rsp_pv_q;
  addr_t        rsp_pt_q;
  lbpt_status_e rsp_st_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_new_valid_q <= 1'b1;
    end else if (cfg_i.valid) begin
      cfg_new_valid_q <= cfg_i.data;
    end
  end

  assign advance     = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || advance;
  assign req_xfer    = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      s1_op_q  <= req_i.opcode;
      s1_key_q <= req_i.branch_addr;
      s1_tgt_q <= req_i.target_addr;
      s1_ext_q <= req_i.exit_target;
      s1_lim_q <= req_i.iteration_limit;
    end
  end

  lbpt_lookup #(
    .Entries (TABLE_ENTRIES)
  ) u_lookup (
    .key_i          (s1_key_q),
    .slot_used_i    (slot_used_q),
    .entry_branch_i (entry_branch_q),
    .lookup_o       (lkp),
    .hit_idx_o      (hit_idx),
    .free_idx_o     (free_idx)
  );

  assign sel_loop  = entry_loop_target_q[hit_idx];
  assign sel_exit  = entry_exit_target_q[hit_idx];
  assign sel_cnt   = entry_trip_count_q[hit_idx];
  assign sel_lim   = entry_limit_q[hit_idx];
  assign sel_valid = entry_valid_q[hit_idx];
  assign at_limit  = (sel_cnt == sel_lim);
  assign do_alloc  = advance && (s1_op_q == OP_INSERT) && !lkp.hit && lkp.free_found;

  always_comb begin
    res_pv = 1'b0;
    res_pt = '0;
    res_st = ST_OK;
    case (s1_op_q)
      OP_PREDICT: begin
        if (lkp.hit && sel_valid) begin
          res_pv = 1'b1;
          res_pt = at_limit ? sel_exit : sel_loop;
        end
      end
      OP_TRIP: begin
        if (!lkp.hit) begin
          res_st = ST_TRIP_MISS;
        end
      end
      OP_INSERT: begin
        if (!lkp.hit && !lkp.free_found) begin
          res_st = ST_INSERT_FULL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_used_q <= '0;
    end else if (do_alloc) begin
      slot_used_q[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      case (s1_op_q)
        OP_TRIP: begin
          if (lkp.hit) begin
            entry_trip_count_q[hit_idx] <= at_limit ? '0 : sel_cnt + count_t'(1);
          end
        end
        OP_INSERT: begin
          if (lkp.hit) begin
            entry_limit_q[hit_idx] <= s1_lim_q;
          end else if (lkp.free_found) begin
            entry_branch_q[free_idx]      <= s1_key_q;
            entry_loop_target_q[free_idx] <= s1_tgt_q;
            entry_exit_target_q[free_idx] <= s1_ext_q;
            entry_trip_count_q[free_idx]  <= '0;
            entry_limit_q[free_idx]       <= s1_lim_q;
            entry_valid_q[free_idx]       <= cfg_new_valid_q;
          end
        end
        OP_SQUASH: begin
          if (lkp.hit) begin
            entry_trip_count_q[hit_idx] <= '0;
            if (s1_tgt_q == sel_loop) begin
              entry_valid_q[hit_idx] <= 1'b0;
            end else if (s1_tgt_q == sel_exit) begin
              entry_valid_q[hit_idx] <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_hit_q <= lkp.hit;
      rsp_pv_q  <= res_pv;
      rsp_pt_q  <= res_pt;
      rsp_st_q  <= res_st;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.hit              = rsp_hit_q;
  assign rsp_o.prediction_valid = rsp_pv_q;
  assign rsp_o.predicted_target = rsp_pt_q;
  assign rsp_o.status           = rsp_st_q;

  `LBPT_ASSERT_NOW(a_pred_needs_hit, rsp_valid_q && rsp_pv_q, rsp_hit_q && (rsp_st_q == ST_OK), "prediction without a hit")
  `LBPT_ASSERT_NOW(a_miss_zero_target, rsp_valid_q && !rsp_pv_q, rsp_pt_q == '0, "nonzero target without a prediction")
  `LBPT_ASSERT_NOW(a_trip_miss_no_hit, rsp_valid_q && (rsp_st_q == ST_TRIP_MISS), !rsp_hit_q, "trip miss reported on a hit")
  `LBPT_ASSERT_NEXT(a_alloc_grows, do_alloc, $countones(slot_used_q) == $countones($past(slot_used_q)) + 1, "allocation did not claim one slot")

endmodule
